// File: rtl/core/lz_window_decompressor_core_macros.svh
// Assertion macros for the LZ window decompressor core.
// Included by the top level; no other dependencies.
`ifndef LZ_WINDOW_DECOMPRESSOR_CORE_MACROS_SVH
`define LZ_WINDOW_DECOMPRESSOR_CORE_MACROS_SVH

`ifndef SYNTHESIS
// antecedent implies consequent in the same cycle
`define LZWD_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lz_window_decompressor_core: assertion failed");
// antecedent implies consequent in the next cycle
`define LZWD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lz_window_decompressor_core: assertion failed");
`else
`define LZWD_ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define LZWD_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

// File: rtl/core/lzwd_pkg.sv
// Shared types and constants of the LZ window decompressor core.
// No dependencies.
package lzwd_pkg;

   localparam int WINDOW_DEPTH = 4096;
   localparam int WIN_AW       = $clog2(WINDOW_DEPTH);
   localparam int SIZE_W       = 24;
   localparam int LEN_W        = 5;
   localparam int MIN_LEN      = 3;
   localparam int CMD_DEPTH    = 2;
   localparam int RSP_DEPTH    = 4;
   localparam int RSP_PTR_W    = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W    = $clog2(RSP_DEPTH + 1);
   localparam int CSR_DATA_W   = 32;
   localparam int CSR_ADDR_W   = 3;

   // register index, taken from the word address bit
   localparam logic REG_OUTPUT_SIZE = 1'b0;

   typedef struct packed {
      logic        is_literal;
      logic [7:0]  literal_byte;
      logic [15:0] reference_word;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_of_run;
      logic       all_done;
   } rsp_type;

   // decoded token handed from front to back
   typedef struct packed {
      logic              is_literal;
      logic [7:0]        literal_byte;
      logic [LEN_W-1:0]  length;
      logic [WIN_AW-1:0] distance;   // distance mod window depth
   } cmd_type;

   typedef enum logic {
      BE_IDLE,
      BE_COPY
   } be_state_type;

endpackage

// File: rtl/core/lzwd_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module lzwd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // read returns the old contents on a same-address write
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/lzwd_front.sv
// Front end: decodes incoming tokens into commands and queues them.
// Depends on lzwd_pkg.
module lzwd_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  lzwd_pkg::req_type req_data,
   input  logic             cmd_pop,
   output logic             cmd_empty,
   output lzwd_pkg::cmd_type cmd_data
);
   import lzwd_pkg::*;

   localparam int PTR_W = $clog2(CMD_DEPTH);
   localparam int CNT_W = $clog2(CMD_DEPTH + 1);

   cmd_type          queue_ff [CMD_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   cmd_type          decoded;
   logic             push_ok;
   logic             pop_ok;

   // token decode: length and distance from the reference word
   always_comb begin
      decoded.is_literal   = req_data.is_literal;
      decoded.literal_byte = req_data.literal_byte;
      decoded.length       = {1'b0, req_data.reference_word[15:12]} + LEN_W'(MIN_LEN);
      decoded.distance     = req_data.reference_word[WIN_AW-1:0] + WIN_AW'(1);
   end

   assign req_full  = (count_ff == CNT_W'(CMD_DEPTH));
   assign cmd_empty = (count_ff == '0);
   assign push_ok   = req_push && !req_full;
   assign pop_ok    = cmd_pop && !cmd_empty;
   assign cmd_data  = queue_ff[rd_ptr_ff];

   // queue pointers and fill level
   always_comb begin
      wr_ptr_in = push_ok ? wr_ptr_ff + PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop_ok ? rd_ptr_ff + PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push_ok && !pop_ok) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop_ok && !push_ok) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         queue_ff[wr_ptr_ff] <= decoded;
      end
   end

endmodule

// File: rtl/core/lzwd_rsp_fifo.sv
// Result queue between the back end and the result ports.
// Depends on lzwd_pkg.
module lzwd_rsp_fifo (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  lzwd_pkg::rsp_type             push_data,
   input  logic                          rsp_pop,
   output logic                          rsp_empty,
   output lzwd_pkg::rsp_type             rsp_data,
   output logic [lzwd_pkg::RSP_CNT_W-1:0] count
);
   import lzwd_pkg::*;

   rsp_type              queue_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [RSP_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [RSP_CNT_W-1:0] count_ff, count_in;
   logic                 pop_ok;

   assign rsp_empty = (count_ff == '0);
   assign pop_ok    = rsp_pop && !rsp_empty;
   assign rsp_data  = queue_ff[rd_ptr_ff];
   assign count     = count_ff;

   // back end only pushes when a slot is reserved
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + RSP_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop_ok ? rd_ptr_ff + RSP_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop_ok) begin
         count_in = count_ff + RSP_CNT_W'(1);
      end else if (pop_ok && !push) begin
         count_in = count_ff - RSP_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: rtl/core/lzwd_back.sv
// Back end: runs commands, issues window reads, writes bytes back and emits them.
// Depends on lzwd_pkg and lzwd_ram.
module lzwd_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [lzwd_pkg::SIZE_W-1:0]    output_size,
   input  logic                          cmd_empty,
   input  lzwd_pkg::cmd_type             cmd_data,
   output logic                          cmd_pop,
   input  logic [lzwd_pkg::RSP_CNT_W-1:0] rsp_count,
   output logic                          rsp_push,
   output lzwd_pkg::rsp_type             rsp_wdata
);
   import lzwd_pkg::*;

   // byte in flight between read issue and write-back
   typedef struct packed {
      logic       valid;
      logic       is_literal;
      logic [7:0] literal_byte;
      logic       bypass;      // source is the byte written this same cycle
      logic       hit;         // source slot has been written since reset
      logic       last;
      logic       done;
   } pend_type;

   be_state_type      state_ff, state_in;
   logic [WIN_AW-1:0] iwp_ff, iwp_in;         // write slot of the next issued byte
   logic [SIZE_W-1:0] issued_ff, issued_in;
   logic [WIN_AW-1:0] src_ff, src_in;
   logic [LEN_W-1:0]  left_ff, left_in;
   pend_type          pend_ff, pend_in;
   logic [WIN_AW-1:0] wp_ff, wp_in;           // write slot of the pending byte
   logic [WIN_AW:0]   fill_ff, fill_in;       // slots written since reset, saturating
   logic [7:0]        last_byte_ff;

   logic              can_issue;
   logic              size_reached;
   logic              done_next;
   logic              issue_en;
   logic              issue_lit;
   logic [WIN_AW-1:0] issue_addr;
   logic              issue_last;
   logic [WIN_AW-1:0] ref_src;
   logic [7:0]        ram_q;
   logic [7:0]        wb_byte;

   // a slot in the result queue is reserved for every byte in flight
   assign can_issue = ({1'b0, rsp_count} + {{RSP_CNT_W{1'b0}}, pend_ff.valid})
                      < (RSP_CNT_W + 1)'(RSP_DEPTH);
   assign size_reached = (issued_ff >= output_size);
   assign done_next    = (({1'b0, issued_ff} + (SIZE_W + 1)'(1)) == {1'b0, output_size});
   assign ref_src      = iwp_ff - cmd_data.distance;

   // command sequencer
   always_comb begin
      state_in   = state_ff;
      src_in     = src_ff;
      left_in    = left_ff;
      cmd_pop    = 1'b0;
      issue_en   = 1'b0;
      issue_lit  = 1'b0;
      issue_addr = src_ff;
      issue_last = 1'b0;
      unique case (state_ff)
         BE_IDLE: begin
            issue_addr = ref_src;
            if (!cmd_empty) begin
               if (size_reached) begin
                  cmd_pop = 1'b1;
               end else if (can_issue) begin
                  cmd_pop  = 1'b1;
                  issue_en = 1'b1;
                  if (cmd_data.is_literal) begin
                     issue_lit  = 1'b1;
                     issue_last = 1'b1;
                  end else begin
                     issue_last = done_next;
                     src_in     = ref_src + WIN_AW'(1);
                     left_in    = cmd_data.length - LEN_W'(1);
                     if (!done_next) begin
                        state_in = BE_COPY;
                     end
                  end
               end
            end
         end
         BE_COPY: begin
            if (can_issue) begin
               issue_en   = 1'b1;
               issue_last = (left_ff == LEN_W'(1)) || done_next;
               src_in     = src_ff + WIN_AW'(1);
               left_in    = left_ff - LEN_W'(1);
               if (issue_last) begin
                  state_in = BE_IDLE;
               end
            end
         end
         default: state_in = BE_IDLE;
      endcase
   end

   // issue stage: capture what the write-back needs next cycle
   always_comb begin
      pend_in.valid        = issue_en;
      pend_in.is_literal   = issue_lit;
      pend_in.literal_byte = cmd_data.literal_byte;
      pend_in.bypass       = pend_ff.valid && (issue_addr == wp_ff);
      pend_in.hit          = ({1'b0, issue_addr} < fill_ff);
      pend_in.last         = issue_last;
      pend_in.done         = done_next;
      iwp_in    = issue_en ? iwp_ff + WIN_AW'(1) : iwp_ff;
      issued_in = issue_en ? issued_ff + SIZE_W'(1) : issued_ff;
   end

   // write-back: pick the byte, store it in the window and emit it
   always_comb begin
      if (pend_ff.is_literal) begin
         wb_byte = pend_ff.literal_byte;
      end else if (pend_ff.bypass) begin
         wb_byte = last_byte_ff;
      end else if (pend_ff.hit) begin
         wb_byte = ram_q;
      end else begin
         wb_byte = 8'h00;
      end
      rsp_push              = pend_ff.valid;
      rsp_wdata.out_byte    = wb_byte;
      rsp_wdata.last_of_run = pend_ff.last;
      rsp_wdata.all_done    = pend_ff.done;
      wp_in   = pend_ff.valid ? wp_ff + WIN_AW'(1) : wp_ff;
      fill_in = fill_ff;
      if (pend_ff.valid && (fill_ff != (WIN_AW + 1)'(WINDOW_DEPTH))) begin
         fill_in = fill_ff + (WIN_AW + 1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= BE_IDLE;
         iwp_ff        <= '0;
         issued_ff     <= '0;
         pend_ff.valid <= 1'b0;
         wp_ff         <= '0;
         fill_ff       <= '0;
      end else begin
         state_ff      <= state_in;
         iwp_ff        <= iwp_in;
         issued_ff     <= issued_in;
         pend_ff       <= pend_in;
         wp_ff         <= wp_in;
         fill_ff       <= fill_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      src_ff               <= src_in;
      left_ff              <= left_in;
      if (pend_ff.valid) begin
         last_byte_ff <= wb_byte;
      end
   end

   // history window
   lzwd_ram #(
      .WIDTH (8),
      .DEPTH (WINDOW_DEPTH)
   ) u_window (
      .clock   (clock),
      .wr_en   (pend_ff.valid),
      .wr_addr (wp_ff),
      .wr_data (wb_byte),
      .rd_addr (issue_addr),
      .rd_data (ram_q)
   );

endmodule

// File: rtl/core/lz_window_decompressor_core.sv
// LZ window decompressor core: decoded LZ tokens in, decompressed bytes out.
// Channels: req_* takes one token per transaction (push/full), rsp_* gives one
// byte per transaction (empty/pop), csr_* is an APB-style register port with
// output_size at byte address 0.
// A token passes the token queue, the pending write-back register and the
// result queue before its byte shows on rsp_*. Copies are 3 to 18 bytes long.
// Throughput is one byte per cycle while the result queue has a free slot,
// set by the single window read port and the one-byte write-back stage.
// Copies read the 4096-byte history window; overlapping copies see bytes
// written the cycle before through a forwarding path.
// Once output_size bytes have been produced, further tokens are taken and
// dropped. The last byte of a copy cut short carries last_of_run and all_done.
// Reset is synchronous; it clears counters and queues and marks the whole
// window as unwritten, so unwritten slots read as zero. No clearing pass runs,
// so tokens are taken as soon as reset is released.
// When the receiver stalls, the four-entry result queue fills, the back end
// stops, and the two-entry token queue then asserts req_full.
// Depends on lzwd_pkg, lzwd_front, lzwd_back, lzwd_rsp_fifo, lzwd_ram.
`include "lz_window_decompressor_core_macros.svh"
module lz_window_decompressor_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_push,
   output logic                            req_full,
   input  lzwd_pkg::req_type               req_data,
   output logic                            rsp_empty,
   input  logic                            rsp_pop,
   output lzwd_pkg::rsp_type               rsp_data,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [lzwd_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [lzwd_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [lzwd_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);
   import lzwd_pkg::*;

   logic [SIZE_W-1:0]    output_size_ff, output_size_in;
   logic                 csr_wr;
   logic                 cmd_pop;
   logic                 cmd_empty;
   cmd_type              cmd_data;
   logic                 rsp_push;
   rsp_type              rsp_wdata;
   logic [RSP_CNT_W-1:0] rsp_count;

   // register port
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      output_size_in = output_size_ff;
      if (csr_wr && (csr_paddr[2] == REG_OUTPUT_SIZE)) begin
         output_size_in = csr_pwdata[SIZE_W-1:0];
      end
      unique case (csr_paddr[2])
         REG_OUTPUT_SIZE: csr_prdata = {{(CSR_DATA_W - SIZE_W){1'b0}}, output_size_ff};
         default:         csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         output_size_ff <= '0;
      end else begin
         output_size_ff <= output_size_in;
      end
   end

   lzwd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .cmd_pop   (cmd_pop),
      .cmd_empty (cmd_empty),
      .cmd_data  (cmd_data)
   );

   lzwd_back u_back (
      .clock       (clock),
      .reset       (reset),
      .output_size (output_size_ff),
      .cmd_empty   (cmd_empty),
      .cmd_data    (cmd_data),
      .cmd_pop     (cmd_pop),
      .rsp_count   (rsp_count),
      .rsp_push    (rsp_push),
      .rsp_wdata   (rsp_wdata)
   );

   lzwd_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (rsp_wdata),
      .rsp_pop   (rsp_pop),
      .rsp_empty (rsp_empty),
      .rsp_data  (rsp_data),
      .count     (rsp_count)
   );

   // the back end never pushes into a full result queue
   `LZWD_ASSERT_IMPLY(a_rsp_no_overflow, clock, reset, rsp_push, rsp_count < RSP_CNT_W'(RSP_DEPTH))
   // commands are only taken from a non-empty queue
   `LZWD_ASSERT_IMPLY(a_cmd_no_underflow, clock, reset, cmd_pop, !cmd_empty)
   // reset leaves nothing to deliver
   `LZWD_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, rsp_empty && !req_full)

endmodule
